// File: hdl/stream_frame_header_planner_defines.svh
// ---------------------------------------------------------------------------
// Stream frame header planner: shared assertion macros
// ---------------------------------------------------------------------------
`ifndef STREAM_FRAME_HEADER_PLANNER_DEFINES_SVH
`define STREAM_FRAME_HEADER_PLANNER_DEFINES_SVH

// Check a property on every rising edge while reset is released.
`define SFHP_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define SFHP_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/sfhp_pkg.sv
// ---------------------------------------------------------------------------
// sfhp_pkg
// Types, constants and varint helpers shared by the frame header planner.
// ---------------------------------------------------------------------------
package sfhp_pkg;

  localparam logic [7:0] TYPE_BASE = 8'h08;
  localparam logic [7:0] BIT_FIN   = 8'h01;
  localparam logic [7:0] BIT_LEN   = 8'h02;
  localparam logic [7:0] BIT_OFF   = 8'h04;

  localparam int unsigned QUEUE_DEPTH = 2;

  // Varint length codes
  localparam logic [1:0] VCODE_1 = 2'd0;
  localparam logic [1:0] VCODE_2 = 2'd1;
  localparam logic [1:0] VCODE_4 = 2'd2;
  localparam logic [1:0] VCODE_8 = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TYPE,
    ST_SID,
    ST_OFF,
    ST_LEN
  } back_state_e;

  // One planned frame, handed from the front to the back.
  typedef struct packed {
    logic        encoded;
    logic [7:0]  frame_type;
    logic [61:0] sid;
    logic [1:0]  sid_code;
    logic [61:0] off;
    logic        has_off;
    logic [1:0]  off_code;
    logic        use_len;
    logic [1:0]  len_code;
    logic [15:0] payload_len;
    logic        fin;
    logic [4:0]  header_len;
  } plan_t;

  function automatic logic [1:0] varint_code(input logic [61:0] v);
    if (v[61:6] == '0) begin
      return VCODE_1;
    end else if (v[61:14] == '0) begin
      return VCODE_2;
    end else if (v[61:30] == '0) begin
      return VCODE_4;
    end
    return VCODE_8;
  endfunction

  function automatic logic [3:0] len_of(input logic [1:0] code);
    logic [3:0] n;
    case (code)
      VCODE_1: n = 4'd1;
      VCODE_2: n = 4'd2;
      VCODE_4: n = 4'd4;
      default: n = 4'd8;
    endcase
    return n;
  endfunction

  // Varint with its length code, left aligned so the first byte sits on top.
  function automatic logic [63:0] varint_align(input logic [1:0] code, input logic [61:0] v);
    logic [63:0] w;
    case (code)
      VCODE_1: w = {VCODE_1, v[5:0], 56'd0};
      VCODE_2: w = {VCODE_2, v[13:0], 48'd0};
      VCODE_4: w = {VCODE_4, v[29:0], 32'd0};
      default: w = {VCODE_8, v[61:0]};
    endcase
    return w;
  endfunction

endpackage

// File: hdl/sfhp_queue.sv
// ---------------------------------------------------------------------------
// sfhp_queue
// Short plan queue between the planning front and the byte emitting back.
// ---------------------------------------------------------------------------
module sfhp_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sfhp_pkg::plan_t push_plan_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            head_valid_o,
  output sfhp_pkg::plan_t head_plan_o
);

  localparam int unsigned Depth = sfhp_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  sfhp_pkg::plan_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o       = (cnt_q == CntW'(Depth));
  assign head_valid_o = (cnt_q != '0);
  assign head_plan_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_plan_i;
    end
  end

endmodule

// File: hdl/sfhp_front.sv
// ---------------------------------------------------------------------------
// sfhp_front
// Two-stage planner: classify the request, then size payload and header.
// ---------------------------------------------------------------------------
module sfhp_front #(
  parameter int unsigned SPACE_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            func_i,
  input  logic [61:0]     stream_id_i,
  input  logic [61:0]     offset_i,
  input  logic [61:0]     data_len_i,
  input  logic [61:0]     final_size_i,
  input  logic            fin_allowed_i,
  input  logic [15:0]     capacity_i,
  input  logic            q_full_i,
  output logic            push_o,
  output sfhp_pkg::plan_t plan_o
);

  localparam int unsigned CapW = (SPACE_BITS < 16) ? SPACE_BITS : 16;

  // ---- stage A: varint classes, base header size, FIN distance ----
  logic [61:0] off_eff, diff;
  logic [1:0]  sid_code, off_code, dlen_code;
  logic        has_off, fin_small;
  logic [4:0]  base;

  assign off_eff   = func_i ? final_size_i : offset_i;
  assign diff      = final_size_i - offset_i;
  assign sid_code  = sfhp_pkg::varint_code(stream_id_i);
  assign off_code  = sfhp_pkg::varint_code(off_eff);
  assign dlen_code = sfhp_pkg::varint_code(data_len_i);
  assign has_off   = (off_eff != '0);
  assign fin_small = fin_allowed_i && (offset_i <= final_size_i) && (diff[61:16] == '0);
  assign base      = 5'd1 + 5'(sfhp_pkg::len_of(sid_code))
                   + (has_off ? 5'(sfhp_pkg::len_of(off_code)) : 5'd0);

  logic            a_v_q;
  logic            a_func_q, a_fin_ok_q, a_fin_small_q, a_has_off_q, a_dlen_big_q;
  logic [15:0]     a_diff_lo_q, a_dlen_lo_q;
  logic [61:0]     a_sid_q, a_off_q;
  logic [1:0]      a_sid_code_q, a_off_code_q, a_dlen_code_q;
  logic [4:0]      a_base_q;
  logic [CapW-1:0] a_cap_q;

  logic            b_v_q;
  sfhp_pkg::plan_t b_plan_q;

  logic a_adv, b_adv;

  assign b_adv      = !b_v_q || !q_full_i;
  assign a_adv      = !a_v_q || b_adv;
  assign in_stall_o = !a_adv;
  assign push_o     = b_v_q && !q_full_i;
  assign plan_o     = b_plan_q;

  // ---- stage B: payload sizing on 17-bit values ----
  logic [16:0] cap_x, base_x, rem, lb, dlo;
  logic [16:0] mx0, l0, rev0, l1, rev1, mx_fit;
  logic        c_all, c_rest;
  logic        enc, use_len, fin;
  logic [16:0] actual;
  logic [1:0]  len_code;
  logic [7:0]  frame_type;
  sfhp_pkg::plan_t plan_d;

  assign cap_x  = 17'(a_cap_q);
  assign base_x = 17'(a_base_q);
  assign rem    = cap_x - base_x;
  assign lb     = 17'(sfhp_pkg::len_of(a_dlen_code_q));
  assign dlo    = 17'(a_dlen_lo_q);
  assign c_all  = !a_dlen_big_q && (rem >= lb) && (dlo <= rem - lb);
  assign c_rest = a_dlen_big_q || (dlo >= rem);

  // Up to two revisions of the payload for the size of its own Length varint
  assign mx0    = rem - 17'd1;
  assign l0     = 17'(sfhp_pkg::len_of(sfhp_pkg::varint_code(62'(mx0))));
  assign rev0   = (rem > l0) ? rem - l0 : 17'd0;
  assign l1     = 17'(sfhp_pkg::len_of(sfhp_pkg::varint_code(62'(rev0))));
  assign rev1   = (rem > l1) ? rem - l1 : 17'd0;
  assign mx_fit = (rev0 == mx0) ? mx0 : ((rev1 == rev0) ? rev0 : rev1);

  always_comb begin
    enc     = 1'b0;
    use_len = 1'b0;
    fin     = 1'b0;
    actual  = '0;
    if (a_func_q) begin
      enc = a_fin_ok_q && (cap_x >= base_x);
      fin = 1'b1;
    end else if (base_x < cap_x) begin
      if (c_all) begin
        enc     = 1'b1;
        use_len = 1'b1;
        actual  = dlo;
      end else if (c_rest) begin
        enc    = 1'b1;
        actual = rem;
      end else if (rem >= 17'd2 && mx_fit != '0) begin
        enc     = 1'b1;
        use_len = 1'b1;
        actual  = (mx_fit < dlo) ? mx_fit : dlo;
      end
      fin = a_fin_small_q && (17'(a_diff_lo_q) == actual);
    end
  end

  assign len_code   = sfhp_pkg::varint_code(62'(actual));
  assign frame_type = sfhp_pkg::TYPE_BASE
                    | (a_has_off_q ? sfhp_pkg::BIT_OFF : 8'h00)
                    | (use_len ? sfhp_pkg::BIT_LEN : 8'h00)
                    | (fin ? sfhp_pkg::BIT_FIN : 8'h00);

  always_comb begin
    plan_d = '0;
    if (enc) begin
      plan_d.encoded     = 1'b1;
      plan_d.frame_type  = frame_type;
      plan_d.sid         = a_sid_q;
      plan_d.sid_code    = a_sid_code_q;
      plan_d.off         = a_off_q;
      plan_d.has_off     = a_has_off_q;
      plan_d.off_code    = a_off_code_q;
      plan_d.use_len     = use_len;
      plan_d.len_code    = len_code;
      plan_d.payload_len = actual[15:0];
      plan_d.fin         = fin;
      plan_d.header_len  = a_base_q + (use_len ? 5'(sfhp_pkg::len_of(len_code)) : 5'd0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
    end else begin
      if (a_adv) begin
        a_v_q <= in_valid_i;
      end
      if (b_adv) begin
        b_v_q <= a_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv && in_valid_i) begin
      a_func_q      <= func_i;
      a_fin_ok_q    <= fin_allowed_i;
      a_fin_small_q <= fin_small;
      a_diff_lo_q   <= diff[15:0];
      a_sid_q       <= stream_id_i;
      a_off_q       <= off_eff;
      a_sid_code_q  <= sid_code;
      a_off_code_q  <= off_code;
      a_has_off_q   <= has_off;
      a_dlen_code_q <= dlen_code;
      a_dlen_big_q  <= (data_len_i[61:16] != '0);
      a_dlen_lo_q   <= data_len_i[15:0];
      a_base_q      <= base;
      a_cap_q       <= capacity_i[CapW-1:0];
    end
    if (b_adv && a_v_q) begin
      b_plan_q <= plan_d;
    end
  end

endmodule

// File: hdl/sfhp_back.sv
// ---------------------------------------------------------------------------
// sfhp_back
// Header byte sequencer: walks type, id, offset and length fields of a plan.
// ---------------------------------------------------------------------------
`include "stream_frame_header_planner_defines.svh"

module sfhp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  sfhp_pkg::plan_t head_plan_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      header_byte_o,
  output logic            last_o,
  output logic            encoded_o,
  output logic [15:0]     payload_len_o,
  output logic            len_present_o,
  output logic            fin_set_o,
  output logic [4:0]      header_len_o
);

  sfhp_pkg::back_state_e state_q, state_d;

  logic [4:0]  tot_q;
  logic [3:0]  fcnt_q, fcnt_d;
  logic [7:0]  type_q;
  logic [63:0] sid_sh_q, off_sh_q, len_sh_q;
  logic [1:0]  sid_code_q, off_code_q, len_code_q;
  logic        has_off_q, use_len_q, enc_q, fin_q;
  logic [15:0] pay_q;
  logic [4:0]  hlen_q;

  logic        out_valid_q, last_q, encoded_q, len_present_q, fin_set_q;
  logic [7:0]  header_byte_q;
  logic [15:0] payload_len_q;
  logic [4:0]  header_len_q;

  logic       out_free, emit, load, last_now;
  logic [7:0] byte_now;

  assign out_free = !out_valid_q || !out_stall_i;
  assign emit     = (state_q != sfhp_pkg::ST_IDLE) && out_free;
  assign last_now = (tot_q == 5'd1);
  assign load     = head_valid_i && ((state_q == sfhp_pkg::ST_IDLE) || (emit && last_now));
  assign pop_o    = load;

  // Next state
  always_comb begin
    state_d = state_q;
    if (emit) begin
      if (last_now) begin
        state_d = sfhp_pkg::ST_IDLE;
      end else begin
        case (state_q)
          sfhp_pkg::ST_TYPE: state_d = sfhp_pkg::ST_SID;
          sfhp_pkg::ST_SID: begin
            if (fcnt_q == 4'd1) begin
              state_d = has_off_q ? sfhp_pkg::ST_OFF : sfhp_pkg::ST_LEN;
            end
          end
          sfhp_pkg::ST_OFF: begin
            if (fcnt_q == 4'd1) begin
              state_d = sfhp_pkg::ST_LEN;
            end
          end
          default: state_d = state_q;
        endcase
      end
    end
    if (load) begin
      state_d = sfhp_pkg::ST_TYPE;
    end
  end

  // Outputs: current byte and field byte count
  always_comb begin
    byte_now = type_q;
    fcnt_d   = fcnt_q;
    case (state_q)
      sfhp_pkg::ST_TYPE: begin
        byte_now = type_q;
        fcnt_d   = sfhp_pkg::len_of(sid_code_q);
      end
      sfhp_pkg::ST_SID: begin
        byte_now = sid_sh_q[63:56];
        if (fcnt_q == 4'd1) begin
          fcnt_d = has_off_q ? sfhp_pkg::len_of(off_code_q) : sfhp_pkg::len_of(len_code_q);
        end else begin
          fcnt_d = fcnt_q - 4'd1;
        end
      end
      sfhp_pkg::ST_OFF: begin
        byte_now = off_sh_q[63:56];
        fcnt_d   = (fcnt_q == 4'd1) ? sfhp_pkg::len_of(len_code_q) : fcnt_q - 4'd1;
      end
      sfhp_pkg::ST_LEN: begin
        byte_now = len_sh_q[63:56];
        fcnt_d   = fcnt_q - 4'd1;
      end
      default: begin
        byte_now = type_q;
        fcnt_d   = fcnt_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sfhp_pkg::ST_IDLE;
      tot_q       <= '0;
      fcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        tot_q <= head_plan_i.encoded ? head_plan_i.header_len : 5'd1;
      end else if (emit) begin
        tot_q  <= tot_q - 5'd1;
        fcnt_q <= fcnt_d;
      end
      if (out_free) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      type_q     <= head_plan_i.frame_type;
      sid_sh_q   <= sfhp_pkg::varint_align(head_plan_i.sid_code, head_plan_i.sid);
      off_sh_q   <= sfhp_pkg::varint_align(head_plan_i.off_code, head_plan_i.off);
      len_sh_q   <= sfhp_pkg::varint_align(head_plan_i.len_code, 62'(head_plan_i.payload_len));
      sid_code_q <= head_plan_i.sid_code;
      off_code_q <= head_plan_i.off_code;
      len_code_q <= head_plan_i.len_code;
      has_off_q  <= head_plan_i.has_off;
      use_len_q  <= head_plan_i.use_len;
      enc_q      <= head_plan_i.encoded;
      fin_q      <= head_plan_i.fin;
      pay_q      <= head_plan_i.payload_len;
      hlen_q     <= head_plan_i.header_len;
    end else if (emit) begin
      case (state_q)
        sfhp_pkg::ST_SID: sid_sh_q <= {sid_sh_q[55:0], 8'd0};
        sfhp_pkg::ST_OFF: off_sh_q <= {off_sh_q[55:0], 8'd0};
        sfhp_pkg::ST_LEN: len_sh_q <= {len_sh_q[55:0], 8'd0};
        default: type_q <= type_q;
      endcase
    end
    if (emit) begin
      header_byte_q <= byte_now;
      last_q        <= last_now;
      encoded_q     <= enc_q;
      payload_len_q <= pay_q;
      len_present_q <= use_len_q;
      fin_set_q     <= fin_q;
      header_len_q  <= hlen_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign header_byte_o = header_byte_q;
  assign last_o        = last_q;
  assign encoded_o     = encoded_q;
  assign payload_len_o = payload_len_q;
  assign len_present_o = len_present_q;
  assign fin_set_o     = fin_set_q;
  assign header_len_o  = header_len_q;

  `SFHP_ASSERT(a_noenc_single, clk_i, rst_ni, out_valid_q && !encoded_q |-> last_q, "not-encoded result must be last")
  `SFHP_ASSERT_ALWAYS(a_len_state, clk_i, (state_q == sfhp_pkg::ST_LEN) |-> use_len_q, "length field walked without Length")
  `SFHP_ASSERT(a_sid_end, clk_i, rst_ni, emit && (state_q == sfhp_pkg::ST_SID) && (fcnt_q == 4'd1) && !has_off_q && !use_len_q |-> last_now, "id varint end disagrees with byte count")
  `SFHP_ASSERT(a_busy_count, clk_i, rst_ni, (state_q != sfhp_pkg::ST_IDLE) |-> (tot_q != 5'd0), "busy sequencer with no bytes left")

endmodule

// File: hdl/stream_frame_header_planner.sv
// ---------------------------------------------------------------------------
// stream_frame_header_planner
// Plans a QUIC STREAM frame header and streams its bytes out one per beat.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one request: stream id,
//   extent offset and length, final size, FIN permission and packet space.
//   Output channel (out_valid_o / out_stall_i) returns the header bytes in
//   order (type, stream id, offset when nonzero, Length when present), with
//   last_o on the final byte; per-frame fields repeat on every byte. A
//   request that does not fit yields one byte-less result with encoded_o low.
//   A request passes planner stages A and B and the plan queue before its
//   first byte is registered. Throughput: one header byte per cycle while
//   out_stall_i is low; a request holds the sequencer for its header_len
//   bytes (2 to 21), or one byte-less result when it does not fit, which
//   sets the sustained rate. The two-stage planner and two-entry queue take
//   a new request every cycle while in_stall_o is low, during earlier frames.
//   Reset (rst_ni low) empties the planner, queue and output register.
//   A stall on the output holds the current byte; the queue fills and then
//   in_stall_o rises until the sequencer drains a plan.
// ---------------------------------------------------------------------------
module stream_frame_header_planner #(
  parameter int unsigned SPACE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [61:0] stream_id_i,
  input  logic [61:0] offset_i,
  input  logic [61:0] data_len_i,
  input  logic [61:0] final_size_i,
  input  logic        fin_allowed_i,
  input  logic [15:0] capacity_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  header_byte_o,
  output logic        last_o,
  output logic        encoded_o,
  output logic [15:0] payload_len_o,
  output logic        len_present_o,
  output logic        fin_set_o,
  output logic [4:0]  header_len_o
);

  // Plans travel front -> queue -> back
  sfhp_pkg::plan_t push_plan, head_plan;
  logic            push, q_full, head_valid, pop;

  // Front: classify the request and size the frame
  sfhp_front #(
    .SPACE_BITS (SPACE_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .stream_id_i   (stream_id_i),
    .offset_i      (offset_i),
    .data_len_i    (data_len_i),
    .final_size_i  (final_size_i),
    .fin_allowed_i (fin_allowed_i),
    .capacity_i    (capacity_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .plan_o        (push_plan)
  );

  // Decouple planning from byte emission
  sfhp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_plan_i  (push_plan),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_plan_o  (head_plan)
  );

  // Back: emit header bytes through the output register
  sfhp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_plan_i   (head_plan),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .header_byte_o (header_byte_o),
    .last_o        (last_o),
    .encoded_o     (encoded_o),
    .payload_len_o (payload_len_o),
    .len_present_o (len_present_o),
    .fin_set_o     (fin_set_o),
    .header_len_o  (header_len_o)
  );

endmodule
